### rtl/datagram_prefilter_rate_limit_core_defines.svh
// assertion macros for the datagram pre-filter core
// used by files that carry concurrent checks; expects clock and reset in scope
`ifndef DATAGRAM_PREFILTER_RATE_LIMIT_CORE_DEFINES_SVH
`define DATAGRAM_PREFILTER_RATE_LIMIT_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// property that must hold at every clock edge out of reset
`define DPRL_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// same-cycle implication
`define DPRL_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define DPRL_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);
`else
`define DPRL_ASSERT(lbl, prop, msg)
`define DPRL_ASSERT_IMPL(lbl, ante, cons, msg)
`define DPRL_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/dprl_pkg.sv
// shared types, codes and constants of the datagram pre-filter core
// no dependencies
`timescale 1ns / 1ps

package dprl_pkg;

   localparam int BUCKET_COUNT = 1024;
   localparam int BUCKET_AW    = $clog2(BUCKET_COUNT);
   localparam int TOKEN_W      = 24;
   localparam int TIME_W       = 32;
   localparam int PROD_W       = 2 * TOKEN_W;

   // size rules
   localparam int TYPE_MASK      = 'h0F;
   localparam int REQUEST_BYTES  = 1 + 13 + 8 + 8 + 24 + 1024;
   localparam int MAC_BYTES      = 16;
   localparam int CHALLENGE_BODY = 8 + 300;
   localparam int KEEPALIVE_BODY = 8;
   localparam int MAX_PAYLOAD    = 1200;
   localparam int LENGTH_SLACK   = 256;
   localparam int MAX_LENGTH     = REQUEST_BYTES + LENGTH_SLACK;
   localparam int MAX_SEQ_BYTES  = 8;
   localparam int ONE_TOKEN      = 65536;

   // verdicts
   localparam logic [1:0] VERDICT_ACCEPT       = 2'd0;
   localparam logic [1:0] VERDICT_BAD_SIZE     = 2'd1;
   localparam logic [1:0] VERDICT_BAD_TYPE     = 2'd2;
   localparam logic [1:0] VERDICT_RATE_LIMITED = 2'd3;

   // packet types
   localparam logic [3:0] PTYPE_REQUEST    = 4'd0;
   localparam logic [3:0] PTYPE_DENIED     = 4'd1;
   localparam logic [3:0] PTYPE_CHALLENGE  = 4'd2;
   localparam logic [3:0] PTYPE_RESPONSE   = 4'd3;
   localparam logic [3:0] PTYPE_KEEPALIVE  = 4'd4;
   localparam logic [3:0] PTYPE_PAYLOAD    = 4'd5;
   localparam logic [3:0] PTYPE_DISCONNECT = 4'd6;

   // register map
   localparam int         CSR_ADDR_W         = 4;
   localparam logic [1:0] CSR_FILTER_ENABLED = 2'd0;
   localparam logic [1:0] CSR_SERVER_ROLE    = 2'd1;
   localparam logic [1:0] CSR_BURST_TOKENS   = 2'd2;
   localparam logic [1:0] CSR_REFILL         = 2'd3;

   localparam logic        RST_FILTER_ENABLED = 1'b1;
   localparam logic        RST_SERVER_ROLE    = 1'b1;
   localparam logic [7:0]  RST_BURST_TOKENS   = 8'd4;
   localparam logic [23:0] RST_REFILL         = 24'd66;

   typedef struct packed {
      logic               seen;
      logic [TOKEN_W-1:0] tokens;
      logic [TIME_W-1:0]  last_time;
   } bucket_entry_type;

   localparam int ENTRY_W = $bits(bucket_entry_type);

   typedef struct packed {
      logic [1:0] verdict;
      logic       charge;
   } class_result_type;

   typedef struct packed {
      logic calc_en;
      logic mul_en;
      logic upd_en;
   } charge_ctrl_type;

endpackage

### rtl/dprl_bucket_ram.sv
// generic single-write, single-read synchronous ram, registered read data
// no dependencies
`timescale 1ns / 1ps

module dprl_bucket_ram #(
   parameter int WIDTH = 57,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/dprl_classify.sv
// header checks: length limits, type against role and sequence count, size per type
// depends on dprl_pkg
`timescale 1ns / 1ps

module dprl_classify (
   input  logic                      filter_enabled,
   input  logic                      server_role,
   input  logic [7:0]                prefix_byte,
   input  logic [15:0]               packet_length,
   output dprl_pkg::class_result_type result
);

   logic [3:0]  ptype;
   logic [3:0]  seq;
   logic [15:0] hdr;
   logic [15:0] lo;
   logic [15:0] hi;
   logic        ok;

   assign ptype = prefix_byte[3:0] & 4'(dprl_pkg::TYPE_MASK);
   assign seq   = prefix_byte[7:4];
   assign hdr   = 16'(seq) + 16'd1;

   // allowed size window and role per type
   always_comb begin
      ok = 1'b0;
      lo = '0;
      hi = '0;
      unique case (ptype)
         dprl_pkg::PTYPE_DENIED: begin
            ok = !server_role;
            lo = hdr + 16'(dprl_pkg::MAC_BYTES);
            hi = lo;
         end
         dprl_pkg::PTYPE_CHALLENGE: begin
            ok = !server_role;
            lo = hdr + 16'(dprl_pkg::CHALLENGE_BODY + dprl_pkg::MAC_BYTES);
            hi = lo;
         end
         dprl_pkg::PTYPE_RESPONSE: begin
            ok = server_role;
            lo = hdr + 16'(dprl_pkg::CHALLENGE_BODY + dprl_pkg::MAC_BYTES);
            hi = lo;
         end
         dprl_pkg::PTYPE_KEEPALIVE: begin
            ok = 1'b1;
            lo = hdr + 16'(dprl_pkg::KEEPALIVE_BODY + dprl_pkg::MAC_BYTES);
            hi = lo;
         end
         dprl_pkg::PTYPE_PAYLOAD: begin
            ok = 1'b1;
            lo = hdr + 16'(1 + dprl_pkg::MAC_BYTES);
            hi = hdr + 16'(dprl_pkg::MAX_PAYLOAD + dprl_pkg::MAC_BYTES);
         end
         dprl_pkg::PTYPE_DISCONNECT: begin
            ok = 1'b1;
            lo = hdr + 16'(dprl_pkg::MAC_BYTES);
            hi = lo;
         end
         default: begin
            ok = 1'b0;
         end
      endcase
   end

   always_comb begin
      result.verdict = dprl_pkg::VERDICT_ACCEPT;
      result.charge  = 1'b0;
      if (!filter_enabled) begin
         result.verdict = dprl_pkg::VERDICT_ACCEPT;
      end else if (packet_length == '0 ||
                   packet_length > 16'(dprl_pkg::MAX_LENGTH)) begin
         result.verdict = dprl_pkg::VERDICT_BAD_SIZE;
      end else if (ptype == dprl_pkg::PTYPE_REQUEST) begin
         if (!server_role || prefix_byte != '0) begin
            result.verdict = dprl_pkg::VERDICT_BAD_TYPE;
         end else if (packet_length != 16'(dprl_pkg::REQUEST_BYTES)) begin
            result.verdict = dprl_pkg::VERDICT_BAD_SIZE;
         end else begin
            result.charge = 1'b1;
         end
      end else if (seq == '0 || seq > 4'(dprl_pkg::MAX_SEQ_BYTES)) begin
         result.verdict = dprl_pkg::VERDICT_BAD_TYPE;
      end else if (!ok) begin
         result.verdict = dprl_pkg::VERDICT_BAD_TYPE;
      end else if (packet_length < lo || packet_length > hi) begin
         result.verdict = dprl_pkg::VERDICT_BAD_SIZE;
      end
   end

endmodule

### rtl/dprl_charge.sv
// token bucket refill and charge: elapsed time, refill product, saturate, take one token
// depends on dprl_pkg
`timescale 1ns / 1ps

module dprl_charge (
   input  logic                              clock,
   input  dprl_pkg::charge_ctrl_type          ctrl,
   input  dprl_pkg::bucket_entry_type         rd_entry,
   input  logic [dprl_pkg::TIME_W-1:0]        now_ticks,
   input  logic [7:0]                         burst_tokens,
   input  logic [23:0]                        refill_per_tick,
   output dprl_pkg::bucket_entry_type         wr_entry,
   output logic                               rate_limited
);

   logic                          seen_ff;
   logic [dprl_pkg::TOKEN_W-1:0]  tokens_ff;
   logic [dprl_pkg::TIME_W-1:0]   last_ff;
   logic                          adv_ff;
   logic                          adv_in;
   logic [dprl_pkg::TIME_W-1:0]   elapsed_ff;
   logic [dprl_pkg::TIME_W-1:0]   elapsed_in;
   logic [dprl_pkg::PROD_W-1:0]   prod_ff;
   logic [dprl_pkg::PROD_W-1:0]   prod_in;
   logic                          sat_ff;
   logic                          sat_in;
   logic [dprl_pkg::TOKEN_W-1:0]  newtok_ff;
   logic [dprl_pkg::TOKEN_W-1:0]  newtok_in;
   logic [dprl_pkg::TOKEN_W-1:0]  cap;
   logic [dprl_pkg::PROD_W:0]     sum;

   // stage 1: elapsed time from the stored entry
   assign adv_in     = now_ticks > rd_entry.last_time;
   assign elapsed_in = now_ticks - rd_entry.last_time;

   // stage 2: 24x24 refill product; elapsed 2^24 or more at nonzero refill sets the cap
   assign prod_in = dprl_pkg::PROD_W'(elapsed_ff[dprl_pkg::TOKEN_W-1:0] * refill_per_tick);
   assign sat_in  = (elapsed_ff[dprl_pkg::TIME_W-1:dprl_pkg::TOKEN_W] != '0) &&
                    (refill_per_tick != '0);

   // stage 3: refill and saturate
   assign cap = {burst_tokens, 16'd0};
   assign sum = (dprl_pkg::PROD_W + 1)'(tokens_ff) + (dprl_pkg::PROD_W + 1)'(prod_ff);

   always_comb begin
      if (!seen_ff) begin
         newtok_in = cap;
      end else if (!adv_ff) begin
         newtok_in = tokens_ff;
      end else if (sat_ff || sum > (dprl_pkg::PROD_W + 1)'(cap)) begin
         newtok_in = cap;
      end else begin
         newtok_in = sum[dprl_pkg::TOKEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.calc_en) begin
         seen_ff    <= rd_entry.seen;
         tokens_ff  <= rd_entry.tokens;
         last_ff    <= rd_entry.last_time;
         adv_ff     <= adv_in;
         elapsed_ff <= elapsed_in;
      end
      if (ctrl.mul_en) begin
         prod_ff <= prod_in;
         sat_ff  <= sat_in;
      end
      if (ctrl.upd_en) begin
         newtok_ff <= newtok_in;
      end
   end

   // stage 4: charge one whole token, keep the stored time when it did not advance
   assign rate_limited       = newtok_ff < dprl_pkg::TOKEN_W'(dprl_pkg::ONE_TOKEN);
   assign wr_entry.seen      = 1'b1;
   assign wr_entry.tokens    = rate_limited ? newtok_ff :
                               newtok_ff - dprl_pkg::TOKEN_W'(dprl_pkg::ONE_TOKEN);
   assign wr_entry.last_time = (seen_ff && !adv_ff) ? last_ff : now_ticks;

endmodule

### rtl/datagram_prefilter_rate_limit_core.sv
// Datagram pre-filter with a per-source token-bucket rate limiter. One verdict word
// (accept, bad size, bad type, rate limited) leaves for every header word taken in.
// After reset the block sweeps the whole bucket store to "never seen" and
// holds req_ready low meanwhile; register writes are taken during the sweep. A datagram
// that needs no bucket charge is settled in the cycle it is taken, so
// such words flow at one per cycle while the result register can drain. A connection
// request that passes the checks goes through bucket read, elapsed time, 24x24 refill
// multiply, refill and saturate, then charge with write-back into the same entry. Only
// one word is in work at a time, keeping the bucket read-modify-write free of overlap.
// Registers: 0 filter_enabled, 1 server_role, 2 burst_tokens, 3 refill_per_tick
// (1/65536 token per tick), at byte addresses 0, 4, 8 and 12; write them only while idle.
// depends on dprl_pkg, dprl_classify, dprl_charge, dprl_bucket_ram and the defines header
`timescale 1ns / 1ps
`include "datagram_prefilter_rate_limit_core_defines.svh"

module datagram_prefilter_rate_limit_core (
   input  logic                            clock,
   input  logic                            reset,
   // request words
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_prefix_byte,
   input  logic [15:0]                     req_packet_length,
   input  logic [9:0]                      req_bucket_index,
   input  logic [31:0]                     req_now_ticks,
   // verdict words
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_verdict,
   // register port
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [dprl_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);

   // controller states
   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_CALC  = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_UPD   = 3'd4;
   localparam logic [2:0] ST_CHG   = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic [2:0]                      state_ff;
   logic [2:0]                      state_in;
   logic [dprl_pkg::BUCKET_AW-1:0]  clr_addr_ff;
   logic [dprl_pkg::BUCKET_AW-1:0]  clr_addr_in;
   logic [dprl_pkg::BUCKET_AW-1:0]  idx_ff;
   logic [dprl_pkg::TIME_W-1:0]     now_ff;
   logic [1:0]                      pend_ff;
   logic [1:0]                      pend_in;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic [1:0]                      rsp_verdict_ff;

   // configuration registers
   logic                            filter_enabled_ff;
   logic                            server_role_ff;
   logic [7:0]                      burst_tokens_ff;
   logic [23:0]                     refill_ff;
   logic                            csr_write;
   logic [1:0]                      csr_idx;

   logic                            accept;
   logic                            out_free;
   logic                            out_load;
   logic [1:0]                      out_verdict;
   logic [1:0]                      charge_verdict;

   dprl_pkg::class_result_type      cls;
   dprl_pkg::charge_ctrl_type       ctrl;
   dprl_pkg::bucket_entry_type      rd_entry;
   dprl_pkg::bucket_entry_type      chg_entry;
   dprl_pkg::bucket_entry_type      mem_wr_data;
   logic                            mem_wr_en;
   logic [dprl_pkg::BUCKET_AW-1:0]  mem_wr_addr;
   logic                            rate_limited;
   logic [dprl_pkg::ENTRY_W-1:0]    rd_raw;

   // ---------------------------------------------------------------- register port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_idx   = paddr[dprl_pkg::CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_enabled_ff <= dprl_pkg::RST_FILTER_ENABLED;
         server_role_ff    <= dprl_pkg::RST_SERVER_ROLE;
         burst_tokens_ff   <= dprl_pkg::RST_BURST_TOKENS;
         refill_ff         <= dprl_pkg::RST_REFILL;
      end else if (csr_write) begin
         unique case (csr_idx)
            dprl_pkg::CSR_FILTER_ENABLED: filter_enabled_ff <= pwdata[0];
            dprl_pkg::CSR_SERVER_ROLE:    server_role_ff    <= pwdata[0];
            dprl_pkg::CSR_BURST_TOKENS:   burst_tokens_ff   <= pwdata[7:0];
            dprl_pkg::CSR_REFILL:         refill_ff         <= pwdata[23:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         dprl_pkg::CSR_FILTER_ENABLED: prdata = 32'(filter_enabled_ff);
         dprl_pkg::CSR_SERVER_ROLE:    prdata = 32'(server_role_ff);
         dprl_pkg::CSR_BURST_TOKENS:   prdata = 32'(burst_tokens_ff);
         dprl_pkg::CSR_REFILL:         prdata = 32'(refill_ff);
         default:                      prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- header checks
   dprl_classify u_classify (
      .filter_enabled (filter_enabled_ff),
      .server_role    (server_role_ff),
      .prefix_byte    (req_prefix_byte),
      .packet_length  (req_packet_length),
      .result         (cls)
   );

   // ---------------------------------------------------------------- bucket store
   // read issued as the word is taken, data ready in the first work cycle
   dprl_bucket_ram #(
      .WIDTH (dprl_pkg::ENTRY_W),
      .DEPTH (dprl_pkg::BUCKET_COUNT)
   ) u_bucket_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (accept),
      .rd_addr (req_bucket_index[dprl_pkg::BUCKET_AW-1:0]),
      .rd_data (rd_raw)
   );

   assign rd_entry = rd_raw;

   dprl_charge u_charge (
      .clock           (clock),
      .ctrl            (ctrl),
      .rd_entry        (rd_entry),
      .now_ticks       (now_ff),
      .burst_tokens    (burst_tokens_ff),
      .refill_per_tick (refill_ff),
      .wr_entry        (chg_entry),
      .rate_limited    (rate_limited)
   );

   // ---------------------------------------------------------------- controller
   assign req_ready      = state_ff == ST_IDLE;
   assign accept         = req_valid && req_ready;
   // result register can take a new verdict when empty or draining this cycle
   assign out_free       = !rsp_valid_ff || rsp_ready;
   assign charge_verdict = rate_limited ? dprl_pkg::VERDICT_RATE_LIMITED :
                                          dprl_pkg::VERDICT_ACCEPT;

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      pend_in     = pend_ff;
      out_load    = 1'b0;
      out_verdict = pend_ff;
      ctrl        = '0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = clr_addr_ff;
      mem_wr_data = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            // sweep every entry back to never seen
            mem_wr_en = 1'b1;
            if (clr_addr_ff == dprl_pkg::BUCKET_AW'(dprl_pkg::BUCKET_COUNT - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (cls.charge) begin
                  state_in = ST_CALC;
               end else if (out_free) begin
                  out_load    = 1'b1;
                  out_verdict = cls.verdict;
               end else begin
                  pend_in  = cls.verdict;
                  state_in = ST_DONE;
               end
            end
         end
         ST_CALC: begin
            ctrl.calc_en = 1'b1;
            state_in     = ST_MUL;
         end
         ST_MUL: begin
            ctrl.mul_en = 1'b1;
            state_in    = ST_UPD;
         end
         ST_UPD: begin
            ctrl.upd_en = 1'b1;
            state_in    = ST_CHG;
         end
         ST_CHG: begin
            // write back the charged bucket
            mem_wr_en   = 1'b1;
            mem_wr_addr = idx_ff;
            mem_wr_data = chg_entry;
            if (out_free) begin
               out_load    = 1'b1;
               out_verdict = charge_verdict;
               state_in    = ST_IDLE;
            end else begin
               pend_in  = charge_verdict;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      if (accept) begin
         idx_ff <= req_bucket_index[dprl_pkg::BUCKET_AW-1:0];
         now_ff <= req_now_ticks;
      end
      if (out_load) begin
         rsp_verdict_ff <= out_verdict;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = rsp_verdict_ff;

   // ---------------------------------------------------------------- checks
   `DPRL_ASSERT_IMPL(a_no_overwrite, out_load, !rsp_valid_ff || rsp_ready, "verdict overwritten before it was taken")
   `DPRL_ASSERT_IMPL(a_done_holds_full, state_ff == ST_DONE, rsp_valid_ff, "pending verdict with empty result register")
   `DPRL_ASSERT_IMPL(a_calc_after_take, state_ff == ST_CALC, $past(req_valid && req_ready), "bucket work started without a taken word")
   `DPRL_ASSERT_IMPL(a_charge_marks_seen, state_ff == ST_CHG, mem_wr_en && mem_wr_data.seen, "charged bucket not written back as seen")
   `DPRL_ASSERT_NEXT(a_charge_ends, state_ff == ST_CHG, state_ff == ST_IDLE || state_ff == ST_DONE, "charge step did not finish the word")

endmodule

### sim/tb_top.sv
// self-checking bench for datagram_prefilter_rate_limit_core: headers in, verdicts out
// holds its own model of the length, type and token-bucket rules, checked word by word
// depends on dprl_pkg and the core rtl
`timescale 1ns / 1ps

module tb_top;

   localparam int SETTLE_CYCLES = 16;      // room after the last verdict for stray words
   localparam int DRAIN_LIMIT   = 20000;   // give up waiting for verdicts after this
   localparam int PHASE_WORDS   = 185;     // random headers per register setting
   localparam int PHASE_COUNT   = 10;

   // expected verdicts, worked out from our own copy of the registers and buckets
   class verdict_scoreboard;
      bit         filter_on;
      bit         server_side;
      bit [7:0]   burst;
      bit [23:0]  refill;
      bit         seen[dprl_pkg::BUCKET_COUNT];
      bit [23:0]  tokens[dprl_pkg::BUCKET_COUNT];
      bit [31:0]  last_tick[dprl_pkg::BUCKET_COUNT];
      logic [1:0] verdicts_due[$];
      int         errors;

      function new();
         filter_on   = dprl_pkg::RST_FILTER_ENABLED;
         server_side = dprl_pkg::RST_SERVER_ROLE;
         burst       = dprl_pkg::RST_BURST_TOKENS;
         refill      = dprl_pkg::RST_REFILL;
         foreach (seen[i]) seen[i] = 1'b0;
         errors = 0;
      endfunction

      function void set_reg(logic [1:0] index, logic [31:0] value);
         case (index)
            dprl_pkg::CSR_FILTER_ENABLED: filter_on   = value[0];
            dprl_pkg::CSR_SERVER_ROLE:    server_side = value[0];
            dprl_pkg::CSR_BURST_TOKENS:   burst       = value[7:0];
            dprl_pkg::CSR_REFILL:         refill      = value[23:0];
            default: ;
         endcase
      endfunction

      // refill the bucket for the time gone by, then try to take one whole token
      function logic [1:0] take_token(bit [9:0] slot, bit [31:0] now);
         bit [23:0]       cap;
         longint unsigned elapsed;
         longint unsigned level;
         cap = {burst, 16'h0000};
         if (!seen[slot]) begin
            seen[slot]      = 1'b1;
            tokens[slot]    = cap;
            last_tick[slot] = now;
         end else if (now > last_tick[slot]) begin
            // exact product, up to 56 bits
            elapsed = now - last_tick[slot];
            level   = tokens[slot] + elapsed * refill;
            if (level > cap) level = cap;
            tokens[slot]    = level[23:0];
            last_tick[slot] = now;
         end
         if (tokens[slot] < dprl_pkg::ONE_TOKEN) return dprl_pkg::VERDICT_RATE_LIMITED;
         tokens[slot] = tokens[slot] - dprl_pkg::ONE_TOKEN;
         return dprl_pkg::VERDICT_ACCEPT;
      endfunction

      function logic [1:0] judge_header(bit [7:0] prefix, bit [15:0] len, bit [9:0] slot,
                                        bit [31:0] now);
         bit [3:0] ptype;
         int       seq;
         int       hdr;
         int       lo;
         int       hi;
         bit       allowed;
         if (!filter_on) return dprl_pkg::VERDICT_ACCEPT;
         if (len == 0 || len > dprl_pkg::MAX_LENGTH) return dprl_pkg::VERDICT_BAD_SIZE;
         ptype = prefix & dprl_pkg::TYPE_MASK;
         seq   = prefix[7:4];
         if (ptype == dprl_pkg::PTYPE_REQUEST) begin
            if (!server_side || prefix != 8'h00) return dprl_pkg::VERDICT_BAD_TYPE;
            if (len != dprl_pkg::REQUEST_BYTES) return dprl_pkg::VERDICT_BAD_SIZE;
            return take_token(slot, now);
         end
         if (seq < 1 || seq > dprl_pkg::MAX_SEQ_BYTES) return dprl_pkg::VERDICT_BAD_TYPE;
         hdr     = 1 + seq;
         lo      = hdr + dprl_pkg::MAC_BYTES;
         hi      = lo;
         allowed = 1'b1;
         case (ptype)
            dprl_pkg::PTYPE_DENIED: allowed = !server_side;
            dprl_pkg::PTYPE_CHALLENGE: begin
               allowed = !server_side;
               lo      = hdr + dprl_pkg::CHALLENGE_BODY + dprl_pkg::MAC_BYTES;
               hi      = lo;
            end
            dprl_pkg::PTYPE_RESPONSE: begin
               allowed = server_side;
               lo      = hdr + dprl_pkg::CHALLENGE_BODY + dprl_pkg::MAC_BYTES;
               hi      = lo;
            end
            dprl_pkg::PTYPE_KEEPALIVE: begin
               lo = hdr + dprl_pkg::KEEPALIVE_BODY + dprl_pkg::MAC_BYTES;
               hi = lo;
            end
            dprl_pkg::PTYPE_PAYLOAD: begin
               lo = hdr + 1 + dprl_pkg::MAC_BYTES;
               hi = hdr + dprl_pkg::MAX_PAYLOAD + dprl_pkg::MAC_BYTES;
            end
            dprl_pkg::PTYPE_DISCONNECT: ;
            default: allowed = 1'b0;
         endcase
         if (!allowed) return dprl_pkg::VERDICT_BAD_TYPE;
         if (len < lo || len > hi) return dprl_pkg::VERDICT_BAD_SIZE;
         return dprl_pkg::VERDICT_ACCEPT;
      endfunction

      function void note_header(bit [7:0] prefix, bit [15:0] len, bit [9:0] slot,
                                bit [31:0] now);
         verdicts_due.push_back(judge_header(prefix, len, slot, now));
      endfunction

      function int pending();
         return verdicts_due.size();
      endfunction

      task report(string what);
         errors++;
         $display("%0t  mismatch: %s", $time, what);
      endtask

      task check_verdict(logic [1:0] got);
         logic [1:0] want;
         if (verdicts_due.size() == 0) begin
            report($sformatf("verdict %0d with no header waiting", got));
            return;
         end
         want = verdicts_due.pop_front();
         if (got !== want) report($sformatf("verdict %0d, expected %0d", got, want));
      endtask
   endclass

   // clock and synchronous reset
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #4 clock = ~clock;

   // header channel
   logic        req_valid         = 1'b0;
   logic        req_ready;
   logic [7:0]  req_prefix_byte   = '0;
   logic [15:0] req_packet_length = '0;
   logic [9:0]  req_bucket_index  = '0;
   logic [31:0] req_now_ticks     = '0;

   // verdict channel
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_verdict;

   // register port
   logic                            psel    = 1'b0;
   logic                            penable = 1'b0;
   logic                            pwrite  = 1'b0;
   logic [dprl_pkg::CSR_ADDR_W-1:0] paddr   = '0;
   logic [31:0]                     pwdata  = '0;
   logic [31:0]                     prdata;
   logic                            pready;

   datagram_prefilter_rate_limit_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_prefix_byte   (req_prefix_byte),
      .req_packet_length (req_packet_length),
      .req_bucket_index  (req_bucket_index),
      .req_now_ticks     (req_now_ticks),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_verdict       (rsp_verdict),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   verdict_scoreboard sb = new();

   // idle shaping: each side flips now and then between gappy and back-to-back stretches
   bit        send_calm = 1'b0;
   bit        take_calm = 1'b0;
   bit [31:0] tick_now  = '0;
   bit [9:0]  hot_base  = '0;

   // one header word: optional gap with valid low, then hold valid until taken.
   // entered and left in the time step of a rising edge, so valid gets one update per step
   task send_word(bit [7:0] prefix, bit [15:0] len, bit [9:0] slot, bit [31:0] now);
      int gap;
      if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
      gap = send_calm ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_prefix_byte   <= prefix;
      req_packet_length <= len;
      req_bucket_index  <= slot;
      req_now_ticks     <= now;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      sb.note_header(prefix, len, slot, now);
   endtask

   // setup cycle, access cycle; the register takes the value at the access edge,
   // then the port idles before it may be used again
   task csr_write(logic [1:0] index, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.set_reg(index, value);
      @(posedge clock);
   endtask

   // every verdict in, then a settling wait so a request charge has surely finished
   task wait_drained();
      int guard;
      guard = 0;
      while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task load_registers(bit filt, bit role, bit [7:0] cap, bit [23:0] rate);
      wait_drained();
      csr_write(dprl_pkg::CSR_FILTER_ENABLED, {31'd0, filt});
      csr_write(dprl_pkg::CSR_SERVER_ROLE, {31'd0, role});
      csr_write(dprl_pkg::CSR_BURST_TOKENS, {24'd0, cap});
      csr_write(dprl_pkg::CSR_REFILL, {8'd0, rate});
   endtask

   // time mostly creeps forward; now and then it jumps, stands still, wraps or steps back
   task advance_ticks();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40)      tick_now = tick_now + $urandom_range(0, 3);
      else if (pick < 70) tick_now = tick_now + $urandom_range(0, 1000);
      else if (pick < 85) tick_now = tick_now + $urandom_range(0, 1 << 20);
      else if (pick < 93) tick_now = tick_now;
      else if (pick < 97) tick_now = tick_now + $urandom;
      else                tick_now = tick_now - $urandom_range(0, 1000);
   endtask

   // mostly well-formed headers with random content, the rest noise
   task random_header(output bit [7:0] prefix, output bit [15:0] len,
                      output bit [9:0] slot, output bit [31:0] now);
      int       pick;
      bit [3:0] ptype;
      int       seq;
      int       lo;
      int       hi;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         // connection request, now and then one byte off
         prefix = 8'h00;
         len    = dprl_pkg::REQUEST_BYTES;
         if ($urandom_range(0, 15) == 0) len = $urandom_range(0, 1) ? len + 1 : len - 1;
      end else if (pick < 80) begin
         ptype = $urandom_range(dprl_pkg::PTYPE_DENIED, dprl_pkg::PTYPE_DISCONNECT);
         seq   = $urandom_range(1, dprl_pkg::MAX_SEQ_BYTES);
         lo    = 1 + seq + dprl_pkg::MAC_BYTES;
         hi    = lo;
         case (ptype) inside
            dprl_pkg::PTYPE_CHALLENGE, dprl_pkg::PTYPE_RESPONSE: begin
               lo = lo + dprl_pkg::CHALLENGE_BODY;
               hi = lo;
            end
            dprl_pkg::PTYPE_KEEPALIVE: begin
               lo = lo + dprl_pkg::KEEPALIVE_BODY;
               hi = lo;
            end
            dprl_pkg::PTYPE_PAYLOAD: begin
               hi = lo + dprl_pkg::MAX_PAYLOAD;
               lo = lo + 1;
            end
            default: ;
         endcase
         prefix = {seq[3:0], ptype};
         case ($urandom_range(0, 5))
            0:       len = lo;
            1:       len = hi;
            2:       len = lo - 1;
            3:       len = hi + 1;
            default: len = $urandom_range(lo, hi);
         endcase
      end else begin
         prefix = $urandom;
         case ($urandom_range(0, 4))
            0:       len = $urandom;
            1:       len = 16'd0;
            2:       len = dprl_pkg::MAX_LENGTH;
            3:       len = dprl_pkg::MAX_LENGTH + 1;
            default: len = $urandom_range(1, 1400);
         endcase
      end
      // a few hot buckets per phase so tokens actually run out
      if ($urandom_range(0, 3) != 0) slot = hot_base + $urandom_range(0, 3);
      else                           slot = $urandom_range(0, dprl_pkg::BUCKET_COUNT - 1);
      advance_ticks();
      now = tick_now;
   endtask

   // verdict side: random stall before each word, then ready held until it is taken
   initial begin
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) take_calm = !take_calm;
         stall = take_calm ? 0 : $urandom_range(0, 10);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         sb.check_verdict(rsp_verdict);
      end
   end

   // main sequence
   initial begin
      bit [7:0]  p;
      bit [15:0] l;
      bit [9:0]  s;
      bit [31:0] n;
      bit [23:0] rate;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed part at reset settings: server role, four tokens, slow refill.
      // four requests drain a fresh bucket, the fifth is refused
      repeat (5) send_word(8'h00, dprl_pkg::REQUEST_BYTES, 10'd0, 32'd0);
      send_word(8'h00, dprl_pkg::REQUEST_BYTES - 1, 10'd1, 32'd0);   // request one byte short
      send_word(8'h10, dprl_pkg::REQUEST_BYTES, 10'd1, 32'd0);   // request with sequence bytes
      send_word(8'h00, 16'd0, 10'd1, 32'd0);                        // empty datagram
      send_word({4'd1, dprl_pkg::PTYPE_KEEPALIVE}, 16'hFFFF, 10'd1, 32'd0); // over the cap
      send_word({4'd1, dprl_pkg::PTYPE_KEEPALIVE}, 16'd26, 10'd1, 32'd0);
      send_word({4'd8, dprl_pkg::PTYPE_PAYLOAD}, 16'd25, 10'd1, 32'd0);     // payload one under
      send_word({4'd8, dprl_pkg::PTYPE_PAYLOAD}, 16'd1225, 10'd1, 32'd0);   // largest payload
      send_word({4'd8, dprl_pkg::PTYPE_RESPONSE}, 16'd333, 10'd1, 32'd0);
      send_word({4'd1, dprl_pkg::PTYPE_DENIED}, 16'd18, 10'd1, 32'd0);  // client-only type
      send_word({4'd2, dprl_pkg::PTYPE_CHALLENGE}, 16'd327, 10'd1, 32'd0);
      send_word({4'd1, dprl_pkg::PTYPE_DISCONNECT}, 16'd18, 10'd1, 32'd0);
      send_word({4'd3, 4'd7}, 16'd18, 10'd1, 32'd0);                // unknown type
      send_word(8'hFF, 16'd18, 10'd1, 32'd0);
      send_word({4'd0, dprl_pkg::PTYPE_KEEPALIVE}, 16'd25, 10'd1, 32'd0);   // no sequence bytes
      send_word({4'd9, dprl_pkg::PTYPE_KEEPALIVE}, 16'd34, 10'd1, 32'd0);   // too many of them
      // top bucket at the end of time, then a full-range refill of the drained bucket
      send_word(8'h00, dprl_pkg::REQUEST_BYTES, 10'd1023, 32'hFFFF_FFFF);
      send_word(8'h00, dprl_pkg::REQUEST_BYTES, 10'd0, 32'hFFFF_FFFF);
      req_valid <= 1'b0;

      // client role: challenge and denied pass, requests are refused outright
      load_registers(1'b1, 1'b0, dprl_pkg::RST_BURST_TOKENS, dprl_pkg::RST_REFILL);
      send_word({4'd2, dprl_pkg::PTYPE_CHALLENGE}, 16'd327, 10'd2, 32'd0);
      send_word({4'd1, dprl_pkg::PTYPE_DENIED}, 16'd18, 10'd2, 32'd0);
      send_word(8'h00, dprl_pkg::REQUEST_BYTES, 10'd2, 32'd0);
      req_valid <= 1'b0;

      // filter off lets anything through
      load_registers(1'b0, 1'b1, dprl_pkg::RST_BURST_TOKENS, dprl_pkg::RST_REFILL);
      send_word(8'hFF, 16'd0, 10'd2, 32'd0);
      req_valid <= 1'b0;

      // random part, one register setting per phase, extremes first
      tick_now = '0;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: load_registers(1'b1, 1'b1, dprl_pkg::RST_BURST_TOKENS, dprl_pkg::RST_REFILL);
            1: load_registers(1'b1, 1'b1, 8'd255, 24'hFF_FFFF);
            2: load_registers(1'b1, 1'b1, 8'd1, 24'd0);
            3: load_registers(1'b1, 1'b1, 8'd0, 24'd1000);  // bucket that never holds a token
            4: load_registers(1'b1, 1'b0, 8'd8, 24'd5000);
            5: load_registers(1'b0, 1'b0, 8'd255, 24'd0);
            default: begin
               rate = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4000);
               load_registers(1'b1, $urandom_range(0, 1), $urandom_range(0, 255), rate);
            end
         endcase
         hot_base = $urandom_range(0, dprl_pkg::BUCKET_COUNT - 4);
         repeat (PHASE_WORDS) begin
            random_header(p, l, s, n);
            send_word(p, l, s, n);
         end
         req_valid <= 1'b0;
      end

      wait_drained();
      if (sb.pending() != 0)
         sb.report($sformatf("%0d verdicts never arrived", sb.pending()));
      if (sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #4_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
